>>> rtl/ibr_pkg.sv
// Shared types, codes and defaults for the interleaved-bitplane body decoder.
`default_nettype none

package ibr_pkg;

   localparam int DefaultMaxPlanes   = 6;
   localparam int DefaultMaxRowBytes = 255;

   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 10;

   localparam logic [CsrIndexWidth-1:0] CsrCompressed  = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CsrBytesPerRow = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CsrPlaneCount  = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CsrRowCount    = 3'd3;

   localparam logic       ResetCompressed  = 1'b1;
   localparam logic [7:0] ResetBytesPerRow = 8'd40;
   localparam logic [2:0] ResetPlaneCount  = 3'd5;
   localparam logic [9:0] ResetRowCount    = 10'd256;

   localparam logic [7:0] ControlNoop = 8'd128;

   typedef enum logic [3:0] {
      PhControl  = 4'b0001,
      PhLiteral  = 4'b0010,
      PhRunValue = 4'b0100,
      PhDiscard  = 4'b1000
   } phase_type;

   typedef struct packed {
      logic       compressed;
      logic [7:0] row_limit;
      logic [3:0] plane_limit;
      logic [9:0] row_total;
   } cfg_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] pixel_byte;
      logic [7:0] repeat_count;
      logic [7:0] start_column;
      logic [2:0] plane_index;
      logic [9:0] row_index;
      logic       row_end;
      logic       image_end;
      logic       overrun;
   } seg_type;

endpackage

`default_nettype wire

>>> rtl/ilbm_byterun1_body_decoder.sv
// Top level of the run-length image body decoder.
// Accepts one body byte per clock unless stalled and produces at most one row segment per byte
// in the next cycle from a single result register; req_ready drops only while that register
// holds a segment that is not being taken in the same cycle. Throughput is therefore one byte
// per cycle, set by the single decode state update per byte. Configuration writes are always
// taken (csr_ready is tied high) and are meant for idle periods. No clearing pass after reset.
`default_nettype none

module ilbm_byterun1_body_decoder
   import ibr_pkg::*;
#(
   parameter int MAX_PLANES    = DefaultMaxPlanes,
   parameter int MAX_ROW_BYTES = DefaultMaxRowBytes
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [7:0]               req_data_byte,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [7:0]                    rsp_pixel_byte,
   output logic [7:0]                    rsp_repeat_count,
   output logic [7:0]                    rsp_start_column,
   output logic [2:0]                    rsp_plane_index,
   output logic [9:0]                    rsp_row_index,
   output logic                          rsp_row_end,
   output logic                          rsp_image_end,
   output logic                          rsp_overrun,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [CsrDataWidth-1:0]  csr_data
);

   cfg_type cfg;
   seg_type seg;
   seg_type held;
   logic    accept;

   assign csr_ready = 1'b1;
   assign req_ready = !held.valid || rsp_ready;
   assign accept    = req_valid && req_ready;

   ibr_cfg_regs #(
      .MAX_PLANES    (MAX_PLANES),
      .MAX_ROW_BYTES (MAX_ROW_BYTES)
   ) u_cfg (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   ibr_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .accept    (accept),
      .data_byte (req_data_byte),
      .seg       (seg)
   );

   ibr_out_reg u_out (
      .clock (clock),
      .reset (reset),
      .load  (accept),
      .seg   (seg),
      .take  (rsp_ready),
      .held  (held)
   );

   assign rsp_valid        = held.valid;
   assign rsp_pixel_byte   = held.pixel_byte;
   assign rsp_repeat_count = held.repeat_count;
   assign rsp_start_column = held.start_column;
   assign rsp_plane_index  = held.plane_index;
   assign rsp_row_index    = held.row_index;
   assign rsp_row_end      = held.row_end;
   assign rsp_image_end    = held.image_end;
   assign rsp_overrun      = held.overrun;

`ifndef SYNTHESIS
   // a held segment that is not taken must stall the input side
   a_stall_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input accepted while result stalled");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_repeat_count != 8'd0) && (rsp_repeat_count <= 8'd128))
      else $error("repeat count out of range");

   a_image_end_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_image_end |-> rsp_row_end && (rsp_start_column == 8'd0 ||
         rsp_repeat_count != 8'd0))
      else $error("image end without row end");
`endif

endmodule

`default_nettype wire

>>> rtl/ibr_cfg_regs.sv
// Configuration registers with the clamped limits derived from them.
`default_nettype none

module ibr_cfg_regs
   import ibr_pkg::*;
#(
   parameter int MAX_PLANES    = DefaultMaxPlanes,
   parameter int MAX_ROW_BYTES = DefaultMaxRowBytes
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     wr_en,
   input  wire logic [CsrIndexWidth-1:0] wr_index,
   input  wire logic [CsrDataWidth-1:0]  wr_data,
   output cfg_type                       cfg
);

   localparam logic [7:0] RowMax   = 8'(MAX_ROW_BYTES);
   localparam logic [3:0] PlaneMax = 4'(MAX_PLANES);

   logic       compressed_ff;
   logic [7:0] bytes_per_row_ff;
   logic [2:0] plane_count_ff;
   logic [9:0] row_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         compressed_ff    <= ResetCompressed;
         bytes_per_row_ff <= ResetBytesPerRow;
         plane_count_ff   <= ResetPlaneCount;
         row_count_ff     <= ResetRowCount;
      end else if (wr_en) begin
         case (wr_index)
            CsrCompressed:  compressed_ff    <= wr_data[0];
            CsrBytesPerRow: bytes_per_row_ff <= wr_data[7:0];
            CsrPlaneCount:  plane_count_ff   <= wr_data[2:0];
            CsrRowCount:    row_count_ff     <= wr_data[9:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.compressed = compressed_ff;
      if (bytes_per_row_ff == 8'd0)
         cfg.row_limit = 8'd1;
      else if (bytes_per_row_ff > RowMax)
         cfg.row_limit = RowMax;
      else
         cfg.row_limit = bytes_per_row_ff;
      if (plane_count_ff == 3'd0)
         cfg.plane_limit = 4'd1;
      else if ({1'b0, plane_count_ff} > PlaneMax)
         cfg.plane_limit = PlaneMax;
      else
         cfg.plane_limit = {1'b0, plane_count_ff};
      cfg.row_total = (row_count_ff == 10'd0) ? 10'd1 : row_count_ff;
   end

endmodule

`default_nettype wire

>>> rtl/ibr_decode.sv
// Run-length decode state and per-byte segment generation.
`default_nettype none

module ibr_decode
   import ibr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cfg_type    cfg,
   input  wire logic       accept,
   input  wire logic [7:0] data_byte,
   output seg_type         seg
);

   phase_type  phase_ff, phase_in;
   logic [7:0] literal_left_ff, literal_left_in;
   logic [7:0] run_length_ff, run_length_in;
   logic [7:0] column_ff, column_in;
   logic [2:0] plane_ff, plane_in;
   logic [9:0] row_ff, row_in;
   logic       finished_ff, finished_in;

   logic [7:0] left, want, cnt, literal_dec;
   logic [2:0] plane_inc;
   logic [9:0] row_inc;
   logic       clipped, rend, wrap, iend, do_emit, in_run, in_literal;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PhControl;
         literal_left_ff <= 8'd0;
         run_length_ff   <= 8'd0;
         column_ff       <= 8'd0;
         plane_ff        <= 3'd0;
         row_ff          <= 10'd0;
         finished_ff     <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         literal_left_ff <= literal_left_in;
         run_length_ff   <= run_length_in;
         column_ff       <= column_in;
         plane_ff        <= plane_in;
         row_ff          <= row_in;
         finished_ff     <= finished_in;
      end
   end

   always_comb begin
      in_run     = cfg.compressed && (phase_ff == PhRunValue);
      in_literal = cfg.compressed && (phase_ff == PhLiteral);
      left       = (column_ff < cfg.row_limit) ? (cfg.row_limit - column_ff) : 8'd1;
      if (in_run)
         want = (run_length_ff != 8'd0) ? run_length_ff : 8'd1;
      else
         want = 8'd1;
      cnt       = (want < left) ? want : left;
      clipped   = want > left;
      rend      = cnt == left;
      plane_inc = plane_ff + 3'd1;
      row_inc   = row_ff + 10'd1;
      wrap      = {1'b0, plane_inc} >= cfg.plane_limit;
      iend      = rend && wrap && ((row_inc >= cfg.row_total) || (row_inc == 10'd0));
      literal_dec = literal_left_ff - 8'd1;

      phase_in        = phase_ff;
      literal_left_in = literal_left_ff;
      run_length_in   = run_length_ff;
      column_in       = column_ff;
      plane_in        = plane_ff;
      row_in          = row_ff;
      finished_in     = finished_ff;
      do_emit         = 1'b0;

      if (accept && !finished_ff) begin
         if (!cfg.compressed) begin
            do_emit = 1'b1;
         end else begin
            case (phase_ff)
               PhControl: begin
                  if (data_byte < ControlNoop) begin
                     literal_left_in = data_byte + 8'd1;
                     phase_in        = PhLiteral;
                  end else if (data_byte > ControlNoop) begin
                     run_length_in = 8'd1 - data_byte;
                     phase_in      = PhRunValue;
                  end
               end
               PhLiteral: begin
                  do_emit         = 1'b1;
                  literal_left_in = literal_dec;
                  if (literal_dec == 8'd0)
                     phase_in = PhControl;
                  else if (rend)
                     phase_in = PhDiscard;
               end
               PhRunValue: begin
                  do_emit       = 1'b1;
                  run_length_in = 8'd0;
                  phase_in      = PhControl;
               end
               PhDiscard: begin
                  literal_left_in = literal_dec;
                  if (literal_dec == 8'd0)
                     phase_in = PhControl;
               end
               default: phase_in = PhControl;
            endcase
         end
      end

      if (do_emit) begin
         column_in   = rend ? 8'd0 : (column_ff + cnt);
         plane_in    = rend ? (wrap ? 3'd0 : plane_inc) : plane_ff;
         row_in      = (rend && wrap) ? row_inc : row_ff;
         finished_in = finished_ff | iend;
      end

      seg.valid        = do_emit;
      seg.pixel_byte   = data_byte;
      seg.repeat_count = cnt;
      seg.start_column = column_ff;
      seg.plane_index  = plane_ff;
      seg.row_index    = row_ff;
      seg.row_end      = rend;
      seg.image_end    = iend;
      seg.overrun      = clipped | (in_literal && rend && (literal_left_ff > 8'd1));
   end

endmodule

`default_nettype wire

>>> rtl/ibr_out_reg.sv
// Result register holding one segment until its transfer completes.
`default_nettype none

module ibr_out_reg
   import ibr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    load,
   input  wire seg_type seg,
   input  wire logic    take,
   output seg_type      held
);

   logic    valid_ff, valid_in;
   seg_type data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load)
         valid_in = seg.valid;
      else if (take)
         valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= 1'b0;
      else
         valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (load && seg.valid)
         data_ff <= seg;
   end

   always_comb begin
      held       = data_ff;
      held.valid = valid_ff;
   end

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the run-length image body decoder: directed table plus random.
`timescale 1ns / 100ps

module testbench;
   import ibr_pkg::*;

   localparam int CycleLimit = 500000;
   localparam int RunBase    = 257;
   localparam logic [CsrIndexWidth-1:0] CsrUnused = 3'd5;

   typedef struct packed {
      logic                     is_csr;
      logic [CsrIndexWidth-1:0] idx;
      logic [CsrDataWidth-1:0]  data;
      logic                     typed;
      seg_type                  fixed;
   } step_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [7:0]               req_data_byte = 8'd0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [7:0]               rsp_pixel_byte;
   logic [7:0]               rsp_repeat_count;
   logic [7:0]               rsp_start_column;
   logic [2:0]               rsp_plane_index;
   logic [9:0]               rsp_row_index;
   logic                     rsp_row_end;
   logic                     rsp_image_end;
   logic                     rsp_overrun;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0]  csr_data = '0;

   // tb-side payload travelling with each byte transfer
   logic    req_typed = 1'b0;
   seg_type req_fixed = '0;

   ilbm_byterun1_body_decoder DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_byte   (rsp_pixel_byte),
      .rsp_repeat_count (rsp_repeat_count),
      .rsp_start_column (rsp_start_column),
      .rsp_plane_index  (rsp_plane_index),
      .rsp_row_index    (rsp_row_index),
      .rsp_row_end      (rsp_row_end),
      .rsp_image_end    (rsp_image_end),
      .rsp_overrun      (rsp_overrun),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // decoder shadow: configuration
   logic       cfg_compressed = ResetCompressed;
   logic [7:0] cfg_row_bytes  = ResetBytesPerRow;
   logic [2:0] cfg_planes     = ResetPlaneCount;
   logic [9:0] cfg_rows       = ResetRowCount;

   // decoder shadow: state
   phase_type  phase    = PhControl;
   logic [7:0] lit_left = '0;
   logic [7:0] run_len  = '0;
   logic [7:0] col      = '0;
   logic [2:0] pln      = '0;
   logic [9:0] row_idx  = '0;
   logic       done     = 1'b0;

   seg_type pending_segments[$];

   int errors          = 0;
   int bytes_queued    = 0;
   int bytes_taken     = 0;
   int segments_seen   = 0;
   int overruns_seen   = 0;
   int image_ends_seen = 0;
   int cycle_count     = 0;
   int send_idle_pct   = 16;
   int recv_idle_pct   = 86;

   task automatic apply_register(input logic [CsrIndexWidth-1:0] idx,
                                 input logic [CsrDataWidth-1:0] data);
      case (idx)
         CsrCompressed:  cfg_compressed = data[0];
         CsrBytesPerRow: cfg_row_bytes  = data[7:0];
         CsrPlaneCount:  cfg_planes     = data[2:0];
         CsrRowCount:    cfg_rows       = data[9:0];
         default: ;
      endcase
   endtask

   // one segment of up to want columns, clipped at the row end
   task automatic cut_segment(input logic [7:0] value, input int want, output seg_type s);
      int lim, left, cnt, plim, rc;
      lim  = (cfg_row_bytes == 0) ? 1 : int'(cfg_row_bytes);
      left = (int'(col) < lim) ? lim - int'(col) : 1;
      cnt  = (want < left) ? want : left;
      s = '0;
      s.valid        = 1'b1;
      s.pixel_byte   = value;
      s.repeat_count = 8'(cnt);
      s.start_column = col;
      s.plane_index  = pln;
      s.row_index    = row_idx;
      s.overrun      = want > left;
      s.row_end      = cnt == left;
      if (s.row_end) begin
         col = '0;
         pln = pln + 3'd1;
         plim = (cfg_planes == 0) ? 1 : int'(cfg_planes);
         if (plim > DefaultMaxPlanes) plim = DefaultMaxPlanes;
         if (int'(pln) >= plim) begin
            pln = '0;
            row_idx = row_idx + 10'd1;
            rc = (cfg_rows == 0) ? 1 : int'(cfg_rows);
            if (int'(row_idx) >= rc || row_idx == 0) begin
               done = 1'b1;
               s.image_end = 1'b1;
            end
         end
      end else begin
         col = col + 8'(cnt);
      end
   endtask

   task automatic decode_byte(input logic [7:0] b, output seg_type s);
      logic more;
      int   want;
      s = '0;
      if (done) return;
      if (!cfg_compressed) begin
         cut_segment(b, 1, s);
         return;
      end
      case (phase)
         PhControl: begin
            if (b < ControlNoop) begin
               lit_left = b + 8'd1;
               phase = PhLiteral;
            end else if (b > ControlNoop) begin
               run_len = 8'(RunBase - int'(b));
               phase = PhRunValue;
            end
         end
         PhLiteral: begin
            more = lit_left > 1;
            cut_segment(b, 1, s);
            if (s.row_end && more) s.overrun = 1'b1;
            lit_left = lit_left - 8'd1;
            if (lit_left == 0) phase = PhControl;
            else if (s.row_end) phase = PhDiscard;
         end
         PhRunValue: begin
            want = (run_len == 0) ? 1 : int'(run_len);
            cut_segment(b, want, s);
            run_len = '0;
            phase = PhControl;
         end
         default: begin
            lit_left = lit_left - 8'd1;
            if (lit_left == 0) phase = PhControl;
         end
      endcase
   endtask

   task automatic report_field(input string name, input int exp_v, input int act_v);
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
   endtask

   task automatic check_segment(input seg_type exp_s, input seg_type act_s);
      if (act_s.pixel_byte !== exp_s.pixel_byte)
         report_field("pixel_byte", exp_s.pixel_byte, act_s.pixel_byte);
      if (act_s.repeat_count !== exp_s.repeat_count)
         report_field("repeat_count", exp_s.repeat_count, act_s.repeat_count);
      if (act_s.start_column !== exp_s.start_column)
         report_field("start_column", exp_s.start_column, act_s.start_column);
      if (act_s.plane_index !== exp_s.plane_index)
         report_field("plane_index", exp_s.plane_index, act_s.plane_index);
      if (act_s.row_index !== exp_s.row_index)
         report_field("row_index", exp_s.row_index, act_s.row_index);
      if (act_s.row_end !== exp_s.row_end)
         report_field("row_end", exp_s.row_end, act_s.row_end);
      if (act_s.image_end !== exp_s.image_end)
         report_field("image_end", exp_s.image_end, act_s.image_end);
      if (act_s.overrun !== exp_s.overrun)
         report_field("overrun", exp_s.overrun, act_s.overrun);
   endtask

   // transfer monitor: checks results, then predicts from accepted bytes
   always @(posedge clock) begin : monitor
      seg_type act_s;
      seg_type exp_s;
      seg_type pred_s;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            act_s = '{1'b1, rsp_pixel_byte, rsp_repeat_count, rsp_start_column,
                      rsp_plane_index, rsp_row_index, rsp_row_end, rsp_image_end,
                      rsp_overrun};
            segments_seen++;
            if (rsp_overrun === 1'b1) overruns_seen++;
            if (rsp_image_end === 1'b1) image_ends_seen++;
            if (pending_segments.size() == 0) begin
               errors++;
               $display("%0t: unexpected segment, expected none, actual value %0d count %0d",
                        $time, rsp_pixel_byte, rsp_repeat_count);
            end else begin
               exp_s = pending_segments.pop_front();
               check_segment(exp_s, act_s);
            end
         end
         if (req_valid && req_ready) begin
            bytes_taken++;
            decode_byte(req_data_byte, pred_s);
            if (req_typed) pending_segments.push_back(req_fixed);
            else if (pred_s.valid) pending_segments.push_back(pred_s);
         end
         if (csr_valid && csr_ready) apply_register(csr_index, csr_data);
      end
   end

   always @(posedge clock) rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timeout after %0d cycles, %0d segments outstanding",
               $time, cycle_count, pending_segments.size());
      $display("Verification failed");
      $finish;
   end

   task automatic send_byte(input logic [7:0] b, input logic typed = 1'b0,
                            input seg_type fixed = '0);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_typed     <= typed;
      req_fixed     <= fixed;
      bytes_queued++;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_segments.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_register(input logic [CsrIndexWidth-1:0] idx,
                                   input logic [CsrDataWidth-1:0] data);
      drain_results();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // mostly well-formed literals and runs, some no-ops and stray bytes
   task automatic send_packet();
      int pick, len, i;
      pick = $urandom_range(99);
      if (pick < 45) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(7);
         send_byte(8'(len));
         for (i = 0; i <= len; i++) send_byte(8'($urandom_range(255)));
      end else if (pick < 85) begin
         send_byte(8'($urandom_range(255, 129)));
         send_byte(8'($urandom_range(255)));
      end else if (pick < 90) begin
         send_byte(ControlNoop);
      end else begin
         send_byte(8'($urandom_range(255)));
      end
   endtask

   task automatic run_setting(input logic mode, input logic [9:0] row_bytes,
                              input logic [9:0] planes, input logic [9:0] rows, input int n,
                              input int send_pct, input int recv_pct, input bit pause_midway);
      int  start;
      bit  paused;
      program_register(CsrCompressed, {9'd0, mode});
      program_register(CsrBytesPerRow, row_bytes);
      program_register(CsrPlaneCount, planes);
      program_register(CsrRowCount, rows);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      start  = bytes_queued;
      paused = 1'b0;
      while (bytes_queued - start < n) begin
         if (pause_midway && !paused && bytes_queued - start >= n / 2) begin
            drain_results();
            paused = 1'b1;
         end
         send_packet();
      end
   endtask

   function automatic step_type byte_row(input logic [7:0] b);
      byte_row = '{1'b0, '0, {2'b00, b}, 1'b0, '0};
   endfunction

   function automatic step_type csr_row(input logic [CsrIndexWidth-1:0] idx,
                                        input logic [CsrDataWidth-1:0] data);
      csr_row = '{1'b1, idx, data, 1'b0, '0};
   endfunction

   function automatic step_type typed_row(input logic [7:0] b, input seg_type s);
      typed_row = '{1'b0, '0, {2'b00, b}, 1'b1, s};
   endfunction

   initial begin : stimulus
      step_type directed[$];
      step_type st;
      int k;

      // reset settings: run-length, 40 bytes per row, 5 planes
      directed.push_back(byte_row(ControlNoop));
      directed.push_back(byte_row(8'h00));
      directed.push_back(typed_row(8'hFF, '{1'b1, 8'hFF, 8'd1, 8'd0, 3'd0, 10'd0,
                                            1'b0, 1'b0, 1'b0}));
      directed.push_back(byte_row(8'h81));
      directed.push_back(typed_row(8'h00, '{1'b1, 8'h00, 8'd39, 8'd1, 3'd0, 10'd0,
                                            1'b1, 1'b0, 1'b1}));
      directed.push_back(byte_row(8'hFE));
      directed.push_back(typed_row(8'hA5, '{1'b1, 8'hA5, 8'd3, 8'd0, 3'd1, 10'd0,
                                            1'b0, 1'b0, 1'b0}));
      // row length lowered below the current column
      directed.push_back(csr_row(CsrBytesPerRow, 10'd2));
      directed.push_back(byte_row(8'hFF));
      directed.push_back(byte_row(8'h5A));
      // literal clipped, tail discarded
      directed.push_back(byte_row(8'h02));
      directed.push_back(byte_row(8'h11));
      directed.push_back(byte_row(8'h22));
      directed.push_back(byte_row(8'h33));
      // raw bytes in the middle of a literal, then resume
      directed.push_back(byte_row(8'h01));
      directed.push_back(byte_row(8'h44));
      directed.push_back(csr_row(CsrCompressed, 10'd0));
      directed.push_back(byte_row(8'h00));
      directed.push_back(byte_row(8'hFF));
      directed.push_back(csr_row(CsrCompressed, 10'd1));
      directed.push_back(byte_row(8'h66));
      directed.push_back(csr_row(CsrUnused, 10'h3FF));
      // zero row length, longest run
      directed.push_back(csr_row(CsrBytesPerRow, 10'd0));
      directed.push_back(byte_row(8'h81));
      directed.push_back(byte_row(8'hC3));
      // plane count beyond range, row length at its maximum, longest literal
      directed.push_back(csr_row(CsrPlaneCount, 10'h3FF));
      directed.push_back(csr_row(CsrBytesPerRow, 10'h3FF));
      directed.push_back(byte_row(8'h7F));
      directed.push_back(byte_row(8'h80));

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (k = 0; k < directed.size(); k++) begin
         st = directed[k];
         if (st.is_csr) program_register(st.idx, st.data);
         else send_byte(st.data[7:0], st.typed, st.fixed);
      end

      run_setting(1'b1, 10'h3FF, 10'd7, 10'd1023, 400, 16, 86, 1'b0);
      run_setting(1'b0, 10'd17, 10'd3, 10'd1023, 200, 16, 86, 1'b0);
      run_setting(1'b1, 10'd0, 10'd0, 10'd1023, 150, 86, 16, 1'b0);
      run_setting(1'b1, 10'd9, 10'd2, 10'd1023, 300, 86, 16, 1'b0);
      run_setting(1'b1, 10'd64, 10'd4, 10'd1023, 500, 0, 0, 1'b1);
      run_setting(1'b0, 10'd1, 10'd6, 10'd1023, 150, 0, 0, 1'b0);
      // row total below the current row: next row end closes the image
      program_register(CsrRowCount, 10'd1);
      run_setting(1'b1, 10'd5, 10'd1, 10'd0, 120, 0, 0, 1'b0);

      drain_results();
      repeat (8) @(posedge clock);

      $display("Summary: %0d bytes transferred, %0d segments checked, %0d clipped",
               bytes_taken, segments_seen, overruns_seen);
      $display("Summary: %0d image end(s), %0d mismatches, raw and run-length settings",
               image_ends_seen, errors);
      if (errors == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule
